[src/fcv_pkg.sv]
// ----------------------------------------------------------------------------
// fcv_pkg: shared types and constants of the frame consensus voter
// Holds the frame, group and result records passed between the voter modules.
// ----------------------------------------------------------------------------
package fcv_pkg;

    // Default width of the stored timestamp.
    localparam int TIME_BITS_DEFAULT = 32;
    // Width of the arrival time field on the input transaction.
    localparam int NOW_WIDTH         = 32;
    // Width of the minimum gap register.
    localparam int GAP_WIDTH         = 16;

    // Minimum gap after reset, in milliseconds.
    localparam logic [GAP_WIDTH-1:0] MIN_GAP_RESET = 16'd100;

    // Operation selector codes.
    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_DISCARD = 1'b1;

    // Capability code for an unknown speed count.
    localparam logic [1:0] CAP_UNKNOWN = 2'd0;

    // Vote counter limits and consensus thresholds.
    localparam logic [7:0] COUNT_MAX  = 8'hFF;
    localparam logic [7:0] COUNT_ONE  = 8'd1;
    localparam logic [7:0] NEED_EXACT = 8'd2;
    localparam logic [7:0] NEED_PLAIN = 8'd3;

    // One received frame without its timestamp.
    typedef struct packed {
        logic       func;
        logic       is_special;
        logic [7:0] rx_byte;
        logic [7:0] norm_byte;
        logic [1:0] capability;
        logic       exact_quality;
        logic       own_byte_valid;
        logic [7:0] own_byte;
    } frame_t;

    // Stored agreement group without its last timestamp.
    typedef struct packed {
        logic       valid;
        logic [7:0] canonical;
        logic [7:0] raw;
        logic [1:0] capability;
        logic       echo;
        logic [7:0] count;
        logic       exact;
    } group_t;

    // One consensus result, packed lowest field last.
    typedef struct packed {
        logic       exact_backed;
        logic [7:0] agree_count;
        logic       possibly_echo;
        logic [1:0] agreed_capability;
        logic [7:0] agreed_raw;
    } result_t;

endpackage

[src/frame_consensus_voter.sv]
// ----------------------------------------------------------------------------
// frame_consensus_voter: votes on received status frames
// Groups frames by canonical byte and reports consensus once enough
// independent frames agree.
// ----------------------------------------------------------------------------
// For a frame that yields consensus, m_tvalid rises once the frame has moved from
// the input register into the result register, which waits while a result stalls.
// Throughput: one frame per cycle while m_tready is high; the group state is
// updated in one pass between the input register and the result register.
// Reset: aresetn low clears the held group, both pipeline stages and sets
// the minimum gap to 100 ms.
module frame_consensus_voter #(
    parameter int TIME_BITS = fcv_pkg::TIME_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: minimum gap in milliseconds.
    input  logic                          cfg_we,
    input  logic [fcv_pkg::GAP_WIDTH-1:0] cfg_wdata,
    // Input frames.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: rx_byte[7:0], norm_byte[15:8], capability[17:16],
    // exact_quality[18], now_ms[50:19], own_byte_valid[51], own_byte[59:52],
    // zero fill [63:60]
    input  logic [63:0]                   s_tdata,
    // tuser: func[0], is_special[1]
    input  logic [1:0]                    s_tuser,
    // Consensus results.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: agreed_raw[7:0], agreed_capability[9:8], possibly_echo[10],
    // agree_count[18:11], exact_backed[19], zero fill [23:20]
    output logic [23:0]                   m_tdata
);
    import fcv_pkg::*;

    // Stored time width: the low TIME_BITS bits of the arrival time, at most NOW_WIDTH.
    localparam int TW = (TIME_BITS < NOW_WIDTH) ? TIME_BITS : NOW_WIDTH;

    logic [GAP_WIDTH-1:0] min_gap_reg;
    logic                 in_valid_reg;
    frame_t               frame_reg;
    logic [TW-1:0]        now_reg;
    group_t               grp_reg;
    group_t               grp_next;
    logic [TW-1:0]        last_reg;
    logic [TW-1:0]        last_next;
    logic                 m_valid_reg;
    result_t              res_reg;
    result_t              res_next;
    logic                 res_valid;
    logic                 advance;
    logic                 s_accept;
    frame_t               frame_in;

    // Unpack the input transaction.
    always_comb begin
        frame_in.func           = s_tuser[0];
        frame_in.is_special     = s_tuser[1];
        frame_in.rx_byte        = s_tdata[7:0];
        frame_in.norm_byte      = s_tdata[15:8];
        frame_in.capability     = s_tdata[17:16];
        frame_in.exact_quality  = s_tdata[18];
        frame_in.own_byte_valid = s_tdata[51];
        frame_in.own_byte       = s_tdata[59:52];
    end

    // Handshake: the held frame moves on when the result slot is free.
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_gap_reg <= MIN_GAP_RESET;
        end else if (cfg_we) begin
            min_gap_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            frame_reg <= frame_in;
            now_reg   <= s_tdata[19 +: TW];
        end
    end

    // Group update for the held frame.
    fcv_vote #(
        .TW (TW)
    ) u_vote (
        .frame     (frame_reg),
        .now       (now_reg),
        .grp       (grp_reg),
        .grp_last  (last_reg),
        .min_gap   (min_gap_reg),
        .grp_next  (grp_next),
        .last_next (last_next),
        .res       (res_next),
        .res_valid (res_valid)
    );

    // Group state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg  <= '0;
            last_reg <= '0;
        end else if (advance) begin
            grp_reg  <= grp_next;
            last_reg <= last_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, res_reg};

endmodule

[src/fcv_vote.sv]
// ----------------------------------------------------------------------------
// fcv_vote: group update logic of the frame consensus voter
// Computes the next group state and an optional consensus result for one frame.
// ----------------------------------------------------------------------------
module fcv_vote #(
    parameter int TW = fcv_pkg::TIME_BITS_DEFAULT
) (
    input  fcv_pkg::frame_t                  frame,
    input  logic [TW-1:0]                    now,
    input  fcv_pkg::group_t                  grp,
    input  logic [TW-1:0]                    grp_last,
    input  logic [fcv_pkg::GAP_WIDTH-1:0]    min_gap,
    output fcv_pkg::group_t                  grp_next,
    output logic [TW-1:0]                    last_next,
    output fcv_pkg::result_t                 res,
    output logic                             res_valid
);
    import fcv_pkg::*;

    logic          echo;
    logic          in_order;
    logic [TW-1:0] age;
    logic          gap_ok;
    logic [7:0]    need;

    // Frame may be our own transmission coming back.
    assign echo     = frame.own_byte_valid && (frame.rx_byte == frame.own_byte);
    assign in_order = (now >= grp_last);
    assign age      = now - grp_last;
    assign gap_ok   = (age >= TW'(min_gap));

    // Next group state and result.
    always_comb begin
        grp_next  = grp;
        last_next = grp_last;
        res_valid = 1'b0;
        need      = NEED_PLAIN;
        if (frame.func == FUNC_DISCARD) begin
            grp_next.valid = 1'b0;
        end else if (!frame.is_special) begin
            if (!grp.valid || (in_order && (frame.norm_byte != grp.canonical))) begin
                // A new group starts with this frame as its single vote.
                grp_next.valid      = 1'b1;
                grp_next.canonical  = frame.norm_byte;
                grp_next.raw        = frame.rx_byte;
                grp_next.capability = frame.capability;
                grp_next.echo       = echo;
                grp_next.count      = COUNT_ONE;
                grp_next.exact      = frame.exact_quality;
                last_next           = now;
            end else if (in_order) begin
                // Matching frame refreshes the group.
                grp_next.raw = frame.rx_byte;
                if ((frame.capability != CAP_UNKNOWN) &&
                    (!echo || (grp.capability == CAP_UNKNOWN))) begin
                    grp_next.capability = frame.capability;
                    grp_next.echo       = echo;
                end
                last_next = now;
                // Only frames far enough apart count as independent votes.
                if (gap_ok) begin
                    if (grp.count != COUNT_MAX) begin
                        grp_next.count = grp.count + 8'd1;
                    end
                    grp_next.exact = grp.exact || frame.exact_quality;
                    need           = grp_next.exact ? NEED_EXACT : NEED_PLAIN;
                    res_valid      = (grp_next.count >= need);
                end
            end
        end
    end

    // Result fields always reflect the updated group.
    assign res.agreed_raw        = grp_next.raw;
    assign res.agreed_capability = grp_next.capability;
    assign res.possibly_echo     = grp_next.echo;
    assign res.agree_count       = grp_next.count;
    assign res.exact_backed      = grp_next.exact;

endmodule

[tb/frame_consensus_voter_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_consensus_voter_checker: consensus predictor and result scoreboard
// Watches the configuration port and both stream channels. Every accepted
// frame is run through a local copy of the voting rules, and any consensus it
// yields is queued. Each accepted result is compared field by field with the
// oldest queued consensus.
// ----------------------------------------------------------------------------
module frame_consensus_voter_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fcv_pkg::GAP_WIDTH-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [63:0]                   s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [23:0]                   m_tdata,
    output int                            fail_count,
    output int                            pending
);
    import fcv_pkg::*;

    // Local copy of the agreement group, with its last timestamp.
    typedef struct packed {
        logic        valid;
        logic [7:0]  canonical;
        logic [7:0]  raw;
        logic [1:0]  capability;
        logic        echo;
        logic [7:0]  count;
        logic        exact;
        logic [31:0] last_ms;
    } vote_group_t;

    vote_group_t          grp;
    logic [GAP_WIDTH-1:0] min_gap;
    result_t              awaited_consensus[$];

    // Apply one frame to the local group and queue the consensus it yields.
    task automatic vote_on_frame(input frame_t f, input logic [31:0] now);
        logic        echo;
        logic [31:0] age;
        logic [7:0]  need;
        result_t     r;
        if (f.func == FUNC_DISCARD) begin
            grp.valid = 1'b0;
            return;
        end
        if (f.is_special)
            return;
        echo = f.own_byte_valid && (f.rx_byte == f.own_byte);
        // A frame starts a new group when none is held, or when it is not
        // older than the group and carries another canonical byte.
        if (!grp.valid || (now >= grp.last_ms && f.norm_byte != grp.canonical)) begin
            grp.valid      = 1'b1;
            grp.canonical  = f.norm_byte;
            grp.raw        = f.rx_byte;
            grp.capability = f.capability;
            grp.echo       = echo;
            grp.count      = COUNT_ONE;
            grp.exact      = f.exact_quality;
            grp.last_ms    = now;
            return;
        end
        if (now < grp.last_ms)
            return;
        age = now - grp.last_ms;
        grp.raw = f.rx_byte;
        // A possible echo of our own byte only fills an unknown capability.
        if (f.capability != CAP_UNKNOWN && (!echo || grp.capability == CAP_UNKNOWN)) begin
            grp.capability = f.capability;
            grp.echo       = echo;
        end
        grp.last_ms = now;
        if (age < {16'd0, min_gap})
            return;
        if (grp.count != COUNT_MAX)
            grp.count = grp.count + 8'd1;
        grp.exact = grp.exact | f.exact_quality;
        need = grp.exact ? NEED_EXACT : NEED_PLAIN;
        if (grp.count < need)
            return;
        r.agreed_raw        = grp.raw;
        r.agreed_capability = grp.capability;
        r.possibly_echo     = grp.echo;
        r.agree_count       = grp.count;
        r.exact_backed      = grp.exact;
        awaited_consensus.push_back(r);
    endtask

    // Compare one result field and log the first few mismatches.
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (fail_count < 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Track configuration, predict on accepted frames, score accepted results.
    always @(posedge aclk) begin
        frame_t  f;
        result_t got;
        result_t want;
        if (!aresetn) begin
            grp        = '0;
            min_gap    = MIN_GAP_RESET;
            fail_count = 0;
            awaited_consensus.delete();
            pending <= 0;
        end else begin
            if (cfg_we)
                min_gap = cfg_wdata;
            if (s_tvalid && s_tready) begin
                f.func           = s_tuser[0];
                f.is_special     = s_tuser[1];
                f.rx_byte        = s_tdata[7:0];
                f.norm_byte      = s_tdata[15:8];
                f.capability     = s_tdata[17:16];
                f.exact_quality  = s_tdata[18];
                f.own_byte_valid = s_tdata[51];
                f.own_byte       = s_tdata[59:52];
                vote_on_frame(f, s_tdata[50:19]);
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[19:0]);
                if (awaited_consensus.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result, tdata %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_consensus.pop_front();
                    check_field("agreed_raw", want.agreed_raw, got.agreed_raw);
                    check_field("agreed_capability", want.agreed_capability,
                                got.agreed_capability);
                    check_field("possibly_echo", want.possibly_echo, got.possibly_echo);
                    check_field("agree_count", want.agree_count, got.agree_count);
                    check_field("exact_backed", want.exact_backed, got.exact_backed);
                end
            end
            pending <= awaited_consensus.size();
        end
    end

endmodule

[tb/frame_consensus_voter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_consensus_voter_tb: stimulus and verdict for the frame consensus voter
// Drives a directed frame list, then runs of agreeing frames with random
// content, gaps and noise under several minimum gap settings, with random
// stalls on both channels until the last phase. Scoring is done by the checker module.
// ----------------------------------------------------------------------------
module frame_consensus_voter_tb;
    import fcv_pkg::*;

    // Cycles with no transaction on either channel before the run is aborted.
    // The slowest correct stretch is a sender gap plus a receiver stall plus
    // the idle wait around a configuration write.
    localparam int STALL_LIMIT = 5000;
    // Width of one frame record, for random fill.
    localparam int FRAME_BITS  = $bits(frame_t);

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [GAP_WIDTH-1:0] cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;

    int                   fail_count;
    int                   pending;
    int                   frames_sent = 0;
    int                   ready_left = 0;
    int                   idle_cycles = 0;
    logic                 calm = 1'b0;
    logic [31:0]          clock_ms = 32'd0;
    logic [15:0]          gap_ms = MIN_GAP_RESET;

    always #6 aclk = ~aclk;

    frame_consensus_voter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    frame_consensus_voter_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side backpressure: random stall and ready bursts, none when calm.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_left <= 0;
        end else if (ready_left == 0) begin
            if (calm || $urandom_range(0, 2) != 0) begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(1, 40);
            end else begin
                // The stall lasts until the count loaded here has run down to zero.
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(0, 17);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Offer one frame, with an occasional idle burst first, and wait for the
    // transaction. Valid stays high afterwards until the next call decides.
    task automatic send_frame(input frame_t f, input logic [31:0] now);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {f.is_special, f.func};
        s_tdata  <= {4'd0, f.own_byte, f.own_byte_valid, now, f.exact_quality,
                     f.capability, f.norm_byte, f.rx_byte};
        do @(posedge aclk); while (!s_tready);
        frames_sent++;
    endtask

    // Plain observed frame with every field given.
    task automatic send_obs(input logic [7:0] raw, input logic [7:0] canon,
                            input logic [1:0] cap, input logic exact,
                            input logic [31:0] now, input logic own_ok,
                            input logic [7:0] own);
        frame_t f;
        f.func           = FUNC_OBSERVE;
        f.is_special     = 1'b0;
        f.rx_byte        = raw;
        f.norm_byte      = canon;
        f.capability     = cap;
        f.exact_quality  = exact;
        f.own_byte_valid = own_ok;
        f.own_byte       = own;
        send_frame(f, now);
    endtask

    // Discard request or special frame, with random payload.
    task automatic send_control(input logic func, input logic special);
        frame_t f;
        f                = frame_t'(FRAME_BITS'($urandom));
        f.rx_byte        = 8'($urandom);
        f.func           = func;
        f.is_special     = special;
        send_frame(f, $urandom);
    endtask

    // Write the minimum gap once the voter has drained.
    task automatic set_gap(input logic [15:0] value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        // Frames that yield nothing may still be in the two stage pipeline.
        repeat (6) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        gap_ms    = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // A run of frames agreeing on one canonical byte. With noise, some frames
    // are discards, special frames, strays of another group or time jumps.
    task automatic play_group(input int n, input bit noisy);
        frame_t     f;
        logic [7:0] canon;
        logic [7:0] base;
        int         pick;
        canon = 8'($urandom);
        base  = 8'($urandom);
        for (int i = 0; i < n; i++) begin
            f.func           = FUNC_OBSERVE;
            f.is_special     = 1'b0;
            f.rx_byte        = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : base ^ 8'($urandom_range(0, 3));
            f.norm_byte      = (noisy && $urandom_range(0, 14) == 0) ? 8'($urandom) : canon;
            f.capability     = 2'($urandom_range(0, 3));
            f.exact_quality  = ($urandom_range(0, 4) == 0);
            f.own_byte_valid = 1'($urandom_range(0, 1));
            f.own_byte       = $urandom_range(0, 1) ? f.rx_byte : 8'($urandom);
            pick = $urandom_range(0, 39);
            if (noisy && pick < 2)
                f.func = FUNC_DISCARD;
            else if (noisy && pick < 4)
                f.is_special = 1'b1;
            // Time step: mostly at or past the gap, sometimes short, rarely a jump.
            pick = $urandom_range(0, 49);
            if (noisy && pick == 0)
                clock_ms = $urandom;
            else if (pick < 10)
                clock_ms += (gap_ms == 0) ? 0 : $urandom_range(0, gap_ms - 1);
            else if (pick < 16)
                clock_ms += 32'(gap_ms);
            else
                clock_ms += 32'(gap_ms) + $urandom_range(0, gap_ms / 4 + 3);
            send_frame(f, clock_ms);
        end
    endtask

    // Noisy runs of random length until about n frames have gone out.
    task automatic run_phase(input int n);
        int start;
        start = frames_sent;
        send_control(FUNC_DISCARD, 1'b0);
        while (frames_sent - start < n)
            play_group($urandom_range(2, 14), 1'b1);
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames under the reset gap of 100 ms.
        send_control(FUNC_DISCARD, 1'b0);                        // nothing held
        send_control(FUNC_OBSERVE, 1'b1);                        // special frame
        send_obs(8'h00, 8'h00, 2'd0, 1'b0, 32'd0, 1'b0, 8'h00);    // starts a group
        send_obs(8'h01, 8'h00, 2'd0, 1'b0, 32'd99, 1'b0, 8'h00);   // gap too short
        send_obs(8'h02, 8'h00, 2'd0, 1'b0, 32'd199, 1'b0, 8'h00);  // two plain votes
        send_obs(8'h03, 8'h00, 2'd0, 1'b1, 32'd299, 1'b0, 8'h00);  // third vote
        send_obs(8'h5A, 8'h00, 2'd3, 1'b0, 32'd399, 1'b1, 8'h5A);  // echo fills unknown
        send_obs(8'h5B, 8'h00, 2'd0, 1'b0, 32'd499, 1'b1, 8'h00);  // unknown keeps
        send_obs(8'h5C, 8'h00, 2'd2, 1'b0, 32'd599, 1'b0, 8'h00);  // clear value wins
        send_obs(8'h5D, 8'h00, 2'd1, 1'b0, 32'd699, 1'b1, 8'h5D);  // echo loses
        send_obs(8'h5E, 8'h00, 2'd1, 1'b0, 32'd10, 1'b0, 8'h00);   // older, ignored
        send_obs(8'hFF, 8'hFF, 2'd3, 1'b1, 32'hFFFF_FF00, 1'b1, 8'h00);
        send_obs(8'hFF, 8'hFF, 2'd3, 1'b1, 32'hFFFF_FFFF, 1'b0, 8'hFF); // exact pair
        send_control(FUNC_OBSERVE, 1'b1);
        send_control(FUNC_DISCARD, 1'b0);
        send_obs(8'hAA, 8'h55, 2'd1, 1'b0, 32'd0, 1'b1, 8'h55);
        send_obs(8'hAA, 8'h55, 2'd1, 1'b0, 32'd100, 1'b1, 8'hAA);  // gap met exactly
        send_obs(8'h55, 8'h55, 2'd2, 1'b0, 32'd200, 1'b0, 8'hAA);

        // Zero gap: every frame counts, a long clean run saturates the count.
        set_gap(16'd0);
        send_control(FUNC_DISCARD, 1'b0);
        clock_ms = $urandom_range(0, 1000);
        play_group(270, 1'b0);

        set_gap(16'hFFFF);
        run_phase(220);
        set_gap(16'($urandom_range(2, 5000)));
        run_phase(220);
        set_gap(MIN_GAP_RESET);
        run_phase(150);

        // Last part runs without idling on either side.
        set_gap(16'd1);
        calm = 1'b1;
        run_phase(170);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
src/fcv_pkg.sv
src/fcv_vote.sv
src/frame_consensus_voter.sv
tb/frame_consensus_voter_checker.sv
tb/frame_consensus_voter_tb.sv
